// ----- hdl/mbc1_pkg.sv -----
// Shared types and constants of the MBC1 bank mapper.
`timescale 1ns / 1ps

package mbc1_pkg;

	localparam int BANK_W    = 7;   // ROM bank number width
	localparam int ROM_OFF_W = 14;  // byte offset inside a 16 KiB ROM bank
	localparam int RAM_OFF_W = 13;  // byte offset inside an 8 KiB RAM bank
	localparam int DIV_STEPS = BANK_W;

	// configuration register indexes
	localparam logic [1:0] REG_ROM_BANK_COUNT = 2'd0;
	localparam logic [1:0] REG_RAM_SIZE       = 2'd1;
	localparam logic [1:0] REG_HAS_RAM        = 2'd2;
	localparam logic [1:0] REG_MULTICART      = 2'd3;

	typedef enum logic [2:0] {
		KIND_ROM_READ  = 3'd0,
		KIND_RAM_READ  = 3'd1,
		KIND_OPEN_BUS  = 3'd2,
		KIND_REG_WRITE = 3'd3,
		KIND_RAM_WRITE = 3'd4,
		KIND_IGNORED   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0]  rom_bank_count;
		logic [15:0] ram_size_bytes;
		logic        has_ram;
		logic        multicart_wiring;
	} cfg_regs_t;

	typedef struct packed {
		logic accept;     // latch the input word
		logic exec;       // apply register write, RAM write or RAM read
		logic div_start;  // load the remainder lanes
		logic div_step;   // one restoring step on both lanes
		logic load_out;   // fill the output register
	} cmd_t;

	typedef struct packed {
		logic div_done;   // the current step is the last one
	} status_t;

endpackage

// ----- hdl/mbc1_cfg.sv -----
// APB configuration registers of the MBC1 bank mapper.
`timescale 1ns / 1ps

module mbc1_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output mbc1_pkg::cfg_regs_t   cfg
);
	import mbc1_pkg::*;

	cfg_regs_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rom_bank_count   <= 8'd2;
			cfg_q.ram_size_bytes   <= 16'd0;
			cfg_q.has_ram          <= 1'b0;
			cfg_q.multicart_wiring <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ROM_BANK_COUNT: cfg_q.rom_bank_count   <= pwdata[7:0];
				REG_RAM_SIZE:       cfg_q.ram_size_bytes   <= pwdata[15:0];
				REG_HAS_RAM:        cfg_q.has_ram          <= pwdata[0];
				REG_MULTICART:      cfg_q.multicart_wiring <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROM_BANK_COUNT: prdata = {24'd0, cfg_q.rom_bank_count};
			REG_RAM_SIZE:       prdata = {16'd0, cfg_q.ram_size_bytes};
			REG_HAS_RAM:        prdata = {31'd0, cfg_q.has_ram};
			REG_MULTICART:      prdata = {31'd0, cfg_q.multicart_wiring};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ----- hdl/mbc1_ctrl.sv -----
// Sequencing state machine of the MBC1 bank mapper.
`timescale 1ns / 1ps

module mbc1_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  mbc1_pkg::status_t status,
	output mbc1_pkg::cmd_t    cmd
);
	import mbc1_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while full");

	a_exec_then_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.div_start)
		else $error("remainder lanes not started after execute");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.div_start, cmd.div_step, cmd.load_out}))
		else $error("more than one command at once");

endmodule

// ----- hdl/mbc1_datapath.sv -----
// Bank registers, remainder lanes, internal RAM and result register of the MBC1 mapper.
`timescale 1ns / 1ps

module mbc1_datapath #(
	parameter int RAM_BYTES     = 32768,
	parameter int MAX_ROM_BANKS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbc1_pkg::cfg_regs_t cfg,
	input  mbc1_pkg::cmd_t      cmd,
	output mbc1_pkg::status_t   status,
	input  logic                s_tuser,
	input  logic [23:0]         s_tdata,
	output logic [2:0]          m_tuser,
	output logic [39:0]         m_tdata
);
	import mbc1_pkg::*;

	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int IDX_W  = 2 + RAM_OFF_W;

	// latched access
	logic        mode_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;

	// bank control registers
	logic        ram_en_q;
	logic [4:0]  bank_low_q;
	logic [1:0]  bank_high_q;
	logic        bmode_q;
	logic        ram_dirty_q;

	// remainder lanes: ROMX and ROM0
	logic [BANK_W-1:0] dx_q, d0_q;
	logic [7:0]        rx_q, r0_q;
	logic [2:0]        step_cnt_q;

	logic [7:0]        ram [RAM_BYTES];
	logic [7:0]        ram_rd_q;

	kind_t             kind_q;
	logic [38:0]       out_q;

	logic [7:0]        eff_banks;
	logic [1:0]        ram_bank;
	logic [IDX_W-1:0]  ram_idx;
	logic              ram_ok;
	logic              is_rom, is_ram;
	logic [4:0]        low_eff;
	logic [BANK_W-1:0] romx_div, rom0_div;
	logic [BANK_W-1:0] romx_bank, rom0_bank, rd_bank;
	logic [7:0]        rx_sh, r0_sh;
	logic              ram_we, ram_re;
	kind_t             kind_d;
	logic [20:0]       rom_addr_d;
	logic [7:0]        rdata_d;

	function automatic logic [1:0] ram_bank_of(input logic [2:0] banks, input logic [1:0] hi);
		case (banks)
			3'd0:    ram_bank_of = 2'd0;
			3'd1:    ram_bank_of = 2'd0;
			3'd2:    ram_bank_of = {1'b0, hi[0]};
			3'd3:    ram_bank_of = (hi == 2'd3) ? 2'd0 : hi;
			default: ram_bank_of = hi;
		endcase
	endfunction

	assign eff_banks = (cfg.rom_bank_count == 8'd0) ? 8'd1 :
		(cfg.rom_bank_count > 8'(MAX_ROM_BANKS)) ? 8'(MAX_ROM_BANKS) : cfg.rom_bank_count;

	assign ram_bank = bmode_q ? ram_bank_of(cfg.ram_size_bytes[15:13], bank_high_q) : 2'd0;
	assign ram_idx  = {ram_bank, addr_q[RAM_OFF_W-1:0]};
	assign is_rom   = ~addr_q[15];
	assign is_ram   = (addr_q[15:13] == 3'b101);
	assign ram_ok   = cfg.has_ram && (cfg.ram_size_bytes != 16'd0) && ram_en_q &&
		({1'b0, ram_idx} < cfg.ram_size_bytes) && (32'(ram_idx) < 32'(RAM_BYTES));
	assign ram_we   = cmd.exec & mode_q & is_ram & ram_ok;
	assign ram_re   = cmd.exec & ~mode_q & is_ram & ram_ok;

	assign low_eff  = (bank_low_q == 5'd0) ? 5'd1 : bank_low_q;
	assign romx_div = cfg.multicart_wiring ? {1'b0, bank_high_q, low_eff[3:0]}
		: {bank_high_q, low_eff};
	assign rom0_div = cfg.multicart_wiring ? {1'b0, bank_high_q, 4'd0} : {bank_high_q, 5'd0};

	assign rx_sh = {rx_q[6:0], dx_q[BANK_W-1]};
	assign r0_sh = {r0_q[6:0], d0_q[BANK_W-1]};

	assign status.div_done = (step_cnt_q == 3'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q    <= 1'b0;
			bank_low_q  <= 5'd0;
			bank_high_q <= 2'd0;
			bmode_q     <= 1'b0;
			ram_dirty_q <= 1'b0;
			step_cnt_q  <= 3'd0;
		end else begin
			if (cmd.exec && mode_q && is_rom) begin
				case (addr_q[14:13])
					2'd0:    ram_en_q    <= (wdata_q[3:0] == 4'hA);
					2'd1:    bank_low_q  <= wdata_q[4:0];
					2'd2:    bank_high_q <= wdata_q[1:0];
					default: bmode_q     <= wdata_q[0];
				endcase
			end
			if (ram_we) begin
				ram_dirty_q <= 1'b1;
			end
			if (cmd.div_start) begin
				step_cnt_q <= 3'd0;
			end else if (cmd.div_step) begin
				step_cnt_q <= step_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= s_tuser;
			addr_q  <= s_tdata[15:0];
			wdata_q <= s_tdata[23:16];
		end
		if (cmd.div_start) begin
			dx_q <= romx_div;
			d0_q <= rom0_div;
			rx_q <= 8'd0;
			r0_q <= 8'd0;
		end else if (cmd.div_step) begin
			dx_q <= {dx_q[BANK_W-2:0], 1'b0};
			d0_q <= {d0_q[BANK_W-2:0], 1'b0};
			rx_q <= (rx_sh >= eff_banks) ? rx_sh - eff_banks : rx_sh;
			r0_q <= (r0_sh >= eff_banks) ? r0_sh - eff_banks : r0_sh;
		end
		if (cmd.load_out) begin
			kind_q <= kind_d;
			out_q  <= {ram_dirty_q, ram_bank, romx_bank, rdata_d, rom_addr_d};
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_idx[RAM_AW-1:0]] <= wdata_q;
		end
		if (ram_re) begin
			ram_rd_q <= ram[ram_idx[RAM_AW-1:0]];
		end
	end

	assign romx_bank = (rx_q == 8'd0) ? BANK_W'(1) : rx_q[BANK_W-1:0];
	assign rom0_bank = bmode_q ? r0_q[BANK_W-1:0] : '0;
	assign rd_bank   = addr_q[14] ? romx_bank : rom0_bank;

	always_comb begin
		kind_d     = KIND_OPEN_BUS;
		rom_addr_d = 21'd0;
		rdata_d    = 8'hFF;
		if (mode_q) begin
			rdata_d = 8'd0;
			if (is_rom) begin
				kind_d = KIND_REG_WRITE;
			end else if (is_ram && ram_ok) begin
				kind_d = KIND_RAM_WRITE;
			end else begin
				kind_d = KIND_IGNORED;
			end
		end else if (is_rom) begin
			if ({1'b0, rd_bank} < eff_banks) begin
				kind_d     = KIND_ROM_READ;
				rdata_d    = 8'd0;
				rom_addr_d = {rd_bank, addr_q[ROM_OFF_W-1:0]};
			end
		end else if (is_ram && ram_ok) begin
			kind_d  = KIND_RAM_READ;
			rdata_d = ram_rd_q;
		end
	end

	assign m_tuser = kind_q;
	assign m_tdata = {1'b0, out_q};

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && status.div_done) |=> (rx_q < eff_banks && r0_q < eff_banks))
		else $error("bank remainder not reduced below the bank count");

	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ram_dirty_q))
		else $error("dirty flag cleared outside reset");

endmodule

// ----- hdl/mbc1_bank_mapper_unit.sv -----
// Top level of the MBC1 cartridge bank mapper.
`timescale 1ns / 1ps

// MBC1 bank mapper: takes one CPU bus access per input word (tuser = 1 for a
// write, tdata = address and write byte) and returns one result word per access.
// Writes below 0x8000 set the RAM enable, low bank, high bank and banking mode
// registers; reads below 0x8000 return a physical ROM byte address; 0xA000-0xBFFF
// reaches the internal banked RAM when present and enabled; anything else is open
// bus or ignored. From acceptance to the loaded result, an access goes through
// these steps: execute the register or RAM access, load the bank remainder lanes,
// run seven restoring steps that reduce the ROMX and ROM0 bank numbers modulo the
// bank count, and register the result once the output register is free. A new
// access is accepted after that, even while the previous result still waits in the
// output register. The internal RAM needs no clearing pass: unwritten bytes read
// undefined. Configure only while no access is in flight.
module mbc1_bank_mapper_unit #(
	parameter int RAM_BYTES     = 32768,
	parameter int MAX_ROM_BANKS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// access input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] mode: 0 read, 1 write
	input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic [39:0] m_tdata    // [20:0] rom_address, [28:21] read_data,
	                               // [35:29] rom_bank, [37:36] ram_bank, [38] dirty
);
	import mbc1_pkg::*;

	cfg_regs_t cfg;
	cmd_t      cmd;
	status_t   status;

	// hold the four configuration registers
	mbc1_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequence each access and own the result valid flag
	mbc1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// bank registers, remainder lanes, RAM and result register
	mbc1_datapath #(
		.RAM_BYTES     (RAM_BYTES),
		.MAX_ROM_BANKS (MAX_ROM_BANKS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.status  (status),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

endmodule
